// ===== design/ppls_pkg.sv =====
// shared types, constants and band classifier for the pulse period level smoother
`default_nettype none
package ppls_pkg;

   localparam int FRACTION_BITS_DEF = 16;

   localparam int CAPTURE_W = 16;
   localparam int TIME_W    = 32;
   localparam int LEVEL_W   = 3;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_RISE_PERIOD   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FALL_PERIOD   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROUND_THRESH  = 2'd2;

   localparam logic [CSR_W-1:0] RISE_PERIOD_RST  = 16'd200;
   localparam logic [CSR_W-1:0] FALL_PERIOD_RST  = 16'd1000;
   localparam logic [CSR_W-1:0] ROUND_THRESH_RST = 16'd9830;

   localparam logic [CAPTURE_W-1:0] BAND_TOP   = 16'd6000;
   localparam logic [CAPTURE_W-1:0] BAND_EDGE1 = 16'd2800;
   localparam logic [CAPTURE_W-1:0] BAND_EDGE2 = 16'd1200;
   localparam logic [CAPTURE_W-1:0] BAND_EDGE3 = 16'd600;
   localparam logic [CAPTURE_W-1:0] BAND_EDGE4 = 16'd300;
   localparam logic [CAPTURE_W-1:0] BAND_LOW   = 16'd100;

   localparam logic [LEVEL_W-1:0] LEVEL_0       = 3'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_1       = 3'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_2       = 3'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_3       = 3'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_4       = 3'd4;
   localparam logic [LEVEL_W-1:0] LEVEL_INVALID = 3'd5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIVIDE,
      ST_MULT,
      ST_UPDATE,
      ST_OUTPUT
   } state_type;

   function automatic logic [LEVEL_W-1:0] band_of(input logic [CAPTURE_W-1:0] p);
      logic [LEVEL_W-1:0] lvl;
      if (p >= BAND_EDGE1 && p < BAND_TOP) begin
         lvl = LEVEL_0;
      end else if (p >= BAND_EDGE2 && p < BAND_EDGE1) begin
         lvl = LEVEL_1;
      end else if (p >= BAND_EDGE3 && p < BAND_EDGE2) begin
         lvl = LEVEL_2;
      end else if (p >= BAND_EDGE4 && p < BAND_EDGE3) begin
         lvl = LEVEL_3;
      end else if (p >= BAND_LOW && p < BAND_EDGE4) begin
         lvl = LEVEL_4;
      end else begin
         lvl = LEVEL_INVALID;
      end
      return lvl;
   endfunction

endpackage
`default_nettype wire

// ===== design/ppls_div.sv =====
// radix-2 restoring divider for the smoother step fraction, one quotient bit per cycle
`default_nettype none
module ppls_div #(
   parameter int FRACTION_BITS = ppls_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               start,
   input  wire logic [ppls_pkg::CAPTURE_W-1:0]     dividend,
   input  wire logic [ppls_pkg::CAPTURE_W-1:0]     divisor,
   output logic                                    done,
   output logic [FRACTION_BITS-1:0]                quotient
);
   import ppls_pkg::*;

   localparam int CNT_W = $clog2(FRACTION_BITS + 1);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic [CAPTURE_W-1:0]     rem_ff, rem_in;
   logic [CAPTURE_W-1:0]     dsr_ff, dsr_in;
   logic [FRACTION_BITS-1:0] quo_ff, quo_in;
   logic [CAPTURE_W:0]       rem2;
   logic [CAPTURE_W:0]       trial;
   logic                     fits;

   assign rem2  = {rem_ff, 1'b0};
   assign trial = rem2 - {1'b0, dsr_ff};
   assign fits  = rem2 >= {1'b0, dsr_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(FRACTION_BITS);
         rem_in  = dividend;
         dsr_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[CAPTURE_W-1:0] : rem2[CAPTURE_W-1:0];
         quo_in = {quo_ff[FRACTION_BITS-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

// ===== design/pulse_period_level_smoother_top.sv =====
// top level of the pulse period level smoother: sequencer, smoother state and result register
//
// usage: a request carries a 16-bit timer capture and the 32-bit millisecond time.
// req_stall stays high while a request is being worked on; one request at a time.
// a request whose capture equals the previous one gives no response and changes nothing.
// otherwise a response carries the filtered level, the wrapped period and the raw band.
// each request goes through the setup, divide, multiply, update and output states;
// divide waits on the divider, but not when elapsed time saturates the step fraction.
// the step fraction comes from a divider that yields one quotient bit a cycle;
// no new request is taken until the sequencer is back in idle.
// the response sits in an output register; while rsp_stall is high it holds, and
// the block may take and work on the next request, waiting before its own output.
// csr writes are taken in any cycle but are meant for idle periods only.
// synchronous reset clears the sequencer, the smoother state (previous capture,
// previous time, accumulator) and loads the csr defaults (200, 1000, 9830).
`default_nettype none
module pulse_period_level_smoother_top #(
   parameter int FRACTION_BITS = ppls_pkg::FRACTION_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire logic [ppls_pkg::CAPTURE_W-1:0]    req_capture_count,
   input  wire logic [ppls_pkg::TIME_W-1:0]       req_now_ms,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output logic [ppls_pkg::LEVEL_W-1:0]           rsp_smoothed_level,
   output logic [ppls_pkg::CAPTURE_W-1:0]         rsp_period_ticks,
   output logic [ppls_pkg::LEVEL_W-1:0]           rsp_raw_level,
   input  wire logic                              csr_write_en,
   input  wire logic [ppls_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [ppls_pkg::CSR_W-1:0]        csr_wdata
);
   import ppls_pkg::*;

   localparam int ACC_W  = FRACTION_BITS + 3;
   localparam int DIFF_W = FRACTION_BITS + 4;
   localparam int STEP_W = FRACTION_BITS + 1;
   localparam int PROD_W = DIFF_W + STEP_W + 1;
   localparam logic [ACC_W-1:0] ACC_MAX = {LEVEL_INVALID, {FRACTION_BITS{1'b0}}};

   state_type state_ff, state_in;

   logic [CSR_W-1:0]     rise_ff, rise_in;
   logic [CSR_W-1:0]     fall_ff, fall_in;
   logic [CSR_W-1:0]     thresh_ff, thresh_in;

   logic [CAPTURE_W-1:0] last_cap_ff, last_cap_in;
   logic [TIME_W-1:0]    last_time_ff, last_time_in;
   logic [ACC_W-1:0]     acc_ff, acc_in;

   logic [CAPTURE_W-1:0] period_ff, period_in;
   logic [LEVEL_W-1:0]   raw_ff, raw_in;
   logic [TIME_W-1:0]    now_ff, now_in;
   logic [TIME_W-1:0]    elapsed_ff, elapsed_in;
   logic [CSR_W-1:0]     per_ff, per_in;
   logic [STEP_W-1:0]    step_ff, step_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]   rsp_smooth_ff, rsp_smooth_in;
   logic [CAPTURE_W-1:0] rsp_period_ff, rsp_period_in;
   logic [LEVEL_W-1:0]   rsp_raw_ff, rsp_raw_in;

   logic                     req_take;
   logic [CAPTURE_W-1:0]     req_period;
   logic [LEVEL_W-1:0]       req_raw;
   logic [ACC_W-1:0]         req_target;
   logic [ACC_W-1:0]         target;
   logic                     saturate;
   logic                     div_start;
   logic                     div_done;
   logic [FRACTION_BITS-1:0] div_quo;
   logic signed [DIFF_W-1:0] diff;
   logic signed [PROD_W-1:0] prod_shift;
   logic signed [DIFF_W-1:0] acc_sum;
   logic [FRACTION_BITS-1:0] frac;
   logic                     round_up;
   logic                     rsp_free;

   ppls_div #(
      .FRACTION_BITS(FRACTION_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (elapsed_ff[CAPTURE_W-1:0]),
      .divisor  (per_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_take   = req_valid && !req_stall;
   assign req_period = req_capture_count - last_cap_ff;
   assign req_raw    = band_of(req_period);
   assign req_target = {req_raw, {FRACTION_BITS{1'b0}}};
   assign target     = {raw_ff, {FRACTION_BITS{1'b0}}};
   assign saturate   = elapsed_ff >= {{(TIME_W-CSR_W){1'b0}}, per_ff};
   assign div_start  = (state_ff == ST_SETUP) && !saturate;
   assign diff       = $signed({1'b0, target}) - $signed({1'b0, acc_ff});
   assign prod_shift = prod_ff >>> FRACTION_BITS;
   assign acc_sum    = $signed({1'b0, acc_ff}) + prod_shift[DIFF_W-1:0];
   assign frac       = acc_ff[FRACTION_BITS-1:0];
   assign round_up   = {frac, 16'b0} > {thresh_ff, {FRACTION_BITS{1'b0}}};
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rise_in   = rise_ff;
      fall_in   = fall_ff;
      thresh_in = thresh_ff;
      if (csr_write_en) begin
         case (csr_index)
            CSR_RISE_PERIOD:  rise_in   = csr_wdata;
            CSR_FALL_PERIOD:  fall_in   = csr_wdata;
            CSR_ROUND_THRESH: thresh_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      last_cap_in   = last_cap_ff;
      last_time_in  = last_time_ff;
      acc_in        = acc_ff;
      period_in     = period_ff;
      raw_in        = raw_ff;
      now_in        = now_ff;
      elapsed_in    = elapsed_ff;
      per_in        = per_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_smooth_in = rsp_smooth_ff;
      rsp_period_in = rsp_period_ff;
      rsp_raw_in    = rsp_raw_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take && (req_capture_count != last_cap_ff)) begin
               last_cap_in = req_capture_count;
               period_in   = req_period;
               raw_in      = req_raw;
               per_in      = (req_target >= acc_ff) ? rise_ff : fall_ff;
               now_in      = req_now_ms;
               elapsed_in  = req_now_ms - last_time_ff;
               state_in    = ST_SETUP;
            end
         end
         ST_SETUP: begin
            state_in = ST_DIVIDE;
         end
         ST_DIVIDE: begin
            if (saturate) begin
               step_in  = {1'b1, {FRACTION_BITS{1'b0}}};
               state_in = ST_MULT;
            end else if (div_done) begin
               step_in  = {1'b0, div_quo};
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            prod_in  = diff * $signed({1'b0, step_ff});
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            acc_in       = acc_sum[ACC_W-1:0];
            last_time_in = now_ff;
            state_in     = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_smooth_in = acc_ff[ACC_W-1:FRACTION_BITS] + LEVEL_W'(round_up);
               rsp_period_in = period_ff;
               rsp_raw_in    = raw_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rise_ff      <= RISE_PERIOD_RST;
         fall_ff      <= FALL_PERIOD_RST;
         thresh_ff    <= ROUND_THRESH_RST;
         last_cap_ff  <= '0;
         last_time_ff <= '0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rise_ff      <= rise_in;
         fall_ff      <= fall_in;
         thresh_ff    <= thresh_in;
         last_cap_ff  <= last_cap_in;
         last_time_ff <= last_time_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      period_ff     <= period_in;
      raw_ff        <= raw_in;
      now_ff        <= now_in;
      elapsed_ff    <= elapsed_in;
      per_ff        <= per_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      rsp_smooth_ff <= rsp_smooth_in;
      rsp_period_ff <= rsp_period_in;
      rsp_raw_ff    <= rsp_raw_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_smoothed_level = rsp_smooth_ff;
   assign rsp_period_ticks   = rsp_period_ff;
   assign rsp_raw_level      = rsp_raw_ff;

   // accumulator stays between its old value and a target of at most the invalid code
   a_acc_range: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= ACC_MAX)
      else $error("accumulator above invalid level");

   // divider only reports while the sequencer waits for it
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> (state_ff == ST_DIVIDE))
      else $error("divider done outside divide state");

   // a new capture starts the sequencer
   a_new_capture: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_capture_count != last_cap_ff)) |=> (state_ff == ST_SETUP))
      else $error("new capture did not start work");

   // an equal capture leaves the smoother untouched
   a_equal_capture: assert property (@(posedge clock) disable iff (reset)
      (req_take && (req_capture_count == last_cap_ff)) |=>
         ((state_ff == ST_IDLE) && $stable(acc_ff) && $stable(last_time_ff)))
      else $error("equal capture changed state");

   // a response level never exceeds the invalid code
   a_rsp_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_smooth_ff <= LEVEL_INVALID))
      else $error("response level out of range");

endmodule
`default_nettype wire
